// File: rtl/tile_constraint_collapse_step_core_defines.svh
// Assertion macros shared by the tile collapse RTL
`ifndef TILE_CONSTRAINT_COLLAPSE_STEP_CORE_DEFINES_SVH
`define TILE_CONSTRAINT_COLLAPSE_STEP_CORE_DEFINES_SVH
// implication checked every clock, skipped while in reset
`define TCC_ASSERT_IMP(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// next-cycle implication
`define TCC_ASSERT_NXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`endif

// File: rtl/tcc_pkg.sv
// Package: constants, tile id table and helpers for the tile collapse core
`default_nettype none
package tcc_pkg;
    localparam int MaxRows   = 32;
    localparam int MaxCols   = 32;
    localparam int TileCount = 11;

    localparam logic [1:0] ModeLoad  = 2'd0;
    localparam logic [1:0] ModeClear = 2'd1;
    localparam logic [1:0] ModeStep  = 2'd2;

    localparam logic [1:0] StatCollapsed = 2'd0;
    localparam logic [1:0] StatComplete  = 2'd1;
    localparam logic [1:0] StatContra    = 2'd2;

    localparam logic CfgRows = 1'b0;
    localparam logic CfgCols = 1'b1;

    function automatic logic [6:0] tile_code_of(input logic [4:0] t);
        logic [6:0] c;
        unique case (t)
            5'd0: c = 7'd1;
            5'd1: c = 7'd38;
            5'd2: c = 7'd39;
            5'd3: c = 7'd40;
            5'd4: c = 7'd47;
            5'd5: c = 7'd48;
            5'd6: c = 7'd49;
            5'd7: c = 7'd56;
            5'd8: c = 7'd57;
            5'd9: c = 7'd58;
            5'd10: c = 7'd65;
            default: c = 7'd0;
        endcase
        return c;
    endfunction
endpackage
`default_nettype wire

// File: rtl/tcc_ram.sv
// Generic single-port-write, one-read synchronous RAM with registered read
`default_nettype none
module tcc_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(Depth)-1:0]  i_waddr,
    input  wire [Width-1:0]          i_wdata,
    input  wire [$clog2(Depth)-1:0]  i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: rtl/tile_constraint_collapse_step_core.sv
// Tile constraint collapse core: cell memory, scan, collapse and neighbor narrowing
// Usage:
//   s_axis: one item per handshake; tdata = {pick, rule_mask, rule_side, rule_tile, mode}.
//   Load (mode 0) writes the adjacency RAM.
//   Clear (mode 1) sweeps all MAX_ROWS*MAX_COLS cells of the cell memory one cell per cycle.
//   Step (mode 2) scans the used grid one cell per cycle through the cell RAM read port
//   (with drain and reread of the best cell), reduces pick modulo the count in a
//   restoring remainder, writes the collapse and narrows up to four neighbors, each
//   read and then written. Complete or contradiction skips the collapse.
//   One result per step on m_axis: tdata = {tile_code, tile_index, col, row, status}.
//   Load and clear give no result; mode 3 is dropped.
//   cfg channel writes rows_used (index 0) and cols_used (index 1); values saturate
//   to the maximum grid size.
//   After reset a clearing pass over all MAX_ROWS*MAX_COLS cells runs before the first
//   item is taken; the adjacency RAM is undefined until loaded.
//   The result sits in an output register; a stalled receiver holds it, and the block
//   takes no new item until it is taken.
`default_nettype none
`include "tile_constraint_collapse_step_core_defines.svh"
module tile_constraint_collapse_step_core #(
    parameter int MAX_ROWS   = tcc_pkg::MaxRows,
    parameter int MAX_COLS   = tcc_pkg::MaxCols,
    parameter int TILE_COUNT = tcc_pkg::TileCount
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] mode, [5:2] rule_tile, [7:6] rule_side, [18:8] rule_mask, [26:19] pick
    input  wire  [31:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // [1:0] status, [6:2] row, [11:7] col, [15:12] tile_index, [22:16] tile_code
    output logic [23:0] m_axis_tdata,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire         i_cfg_index,
    input  wire  [5:0]  i_cfg_data
);
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int Cells = MAX_ROWS * MAX_COLS;
    localparam int AW = $clog2(Cells) > 0 ? $clog2(Cells) : 1;
    localparam int TW = $clog2(TILE_COUNT);
    localparam int NW = $clog2(TILE_COUNT + 1);
    localparam int RuleDepth = TILE_COUNT * 4;
    localparam int RAW = $clog2(RuleDepth);
    localparam int EW = TILE_COUNT + TW + 1;  // cell: done, tile, mask
    localparam int RMaxW = $clog2(MAX_ROWS + 1);
    localparam int CMaxW = $clog2(MAX_COLS + 1);

    typedef enum logic [9:0] {
        ST_CLR   = 10'b0000000001,
        ST_IDLE  = 10'b0000000010,
        ST_SCAN  = 10'b0000000100,
        ST_SDRN  = 10'b0000001000,
        ST_SEL   = 10'b0000010000,
        ST_DIV   = 10'b0000100000,
        ST_PICK  = 10'b0001000000,
        ST_NRD   = 10'b0010000000,
        ST_NWR   = 10'b0100000000,
        ST_OUT   = 10'b1000000000
    } t_state;

    t_state r_st, n_st;
    logic [5:0] r_rows, r_cols;
    logic [RMaxW-1:0] w_rows;
    logic [CMaxW-1:0] w_cols;
    logic [AW:0] r_cnt;
    logic [RW-1:0] r_sr, r_br;
    logic [CW-1:0] r_sc, r_bc;
    logic r_pv;            // read issued last cycle during scan
    logic [RW-1:0] r_pr;
    logic [CW-1:0] r_pc;
    logic [NW-1:0] r_bn;
    logic r_found;
    logic [7:0] r_pick, r_rem;
    logic [TILE_COUNT-1:0] r_bmask;
    logic [TW-1:0] r_tile;
    logic [2:0] r_side;
    logic [23:0] r_out;
    logic r_ov;

    logic we;
    logic [AW-1:0] waddr, raddr;
    logic [EW-1:0] wdata, rdata;
    logic rule_we;
    logic [RAW-1:0] rule_waddr, rule_raddr;
    logic [TILE_COUNT-1:0] rule_rdata;

    tcc_ram #(.Width(EW), .Depth(Cells)) u_cells (
        .i_clk, .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );
    tcc_ram #(.Width(TILE_COUNT), .Depth(RuleDepth)) u_rules (
        .i_clk, .i_we(rule_we), .i_waddr(rule_waddr),
        .i_wdata(s_axis_tdata[8 +: TILE_COUNT]),
        .i_raddr(rule_raddr), .o_rdata(rule_rdata)
    );

    assign w_rows = (r_rows > 6'(MAX_ROWS)) ? RMaxW'(MAX_ROWS) : RMaxW'(r_rows);
    assign w_cols = (r_cols > 6'(MAX_COLS)) ? CMaxW'(MAX_COLS) : CMaxW'(r_cols);

    function automatic logic [AW-1:0] addr_of(input logic [RW-1:0] r, input logic [CW-1:0] c);
        return AW'(r * MAX_COLS + c);
    endfunction

    function automatic logic [NW-1:0] pop(input logic [TILE_COUNT-1:0] m);
        logic [NW-1:0] n;
        n = '0;
        for (int i = 0; i < TILE_COUNT; i++) n = n + NW'(m[i]);
        return n;
    endfunction

    // neighbor for side s of the best cell, with a valid flag
    logic nb_ok;
    logic [RW-1:0] nb_r;
    logic [CW-1:0] nb_c;
    always_comb begin
        nb_ok = 1'b0;
        nb_r = r_br;
        nb_c = r_bc;
        unique case (r_side[1:0])
            2'd0: begin nb_ok = (r_br != '0); nb_r = r_br - 1'b1; end
            2'd1: begin nb_ok = (r_bc != '0); nb_c = r_bc - 1'b1; end
            2'd2: begin nb_ok = (RMaxW'(r_br) + 1'b1 < w_rows); nb_r = r_br + 1'b1; end
            default: begin nb_ok = (CMaxW'(r_bc) + 1'b1 < w_cols); nb_c = r_bc + 1'b1; end
        endcase
    end

    logic acc;
    logic [1:0] in_mode;
    logic [3:0] in_tile;
    assign in_mode = s_axis_tdata[1:0];
    assign in_tile = s_axis_tdata[5:2];
    assign s_axis_tready = (r_st == ST_IDLE) && !r_ov;
    assign acc = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready = 1'b1;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata = r_out;

    logic scan_last;
    assign scan_last = (RMaxW'(r_sr) + 1'b1 >= w_rows) && (CMaxW'(r_sc) + 1'b1 >= w_cols);

    logic [NW-1:0] rd_n;
    assign rd_n = pop(rdata[TILE_COUNT-1:0]);

    // pick-th candidate from the top
    logic [TW-1:0] pick_tile;
    always_comb begin
        logic [NW-1:0] seen;
        logic hit;
        seen = '0;
        hit = 1'b0;
        pick_tile = '0;
        for (int k = TILE_COUNT - 1; k >= 0; k--) begin
            if (r_bmask[k] && !hit) begin
                if (seen == NW'(r_rem)) begin
                    pick_tile = TW'(k);
                    hit = 1'b1;
                end
                seen = seen + 1'b1;
            end
        end
    end

    // restoring remainder of pick by the count, one pick bit per cycle
    logic [3:0] r_dbit;
    logic [8:0] trial;
    assign trial = {r_rem, r_pick[7]} - 9'(r_bn);

    always_comb begin
        n_st = r_st;
        we = 1'b0;
        waddr = addr_of(r_sr, r_sc);
        wdata = {1'b0, TW'(0), {TILE_COUNT{1'b1}}};
        raddr = addr_of(r_sr, r_sc);
        rule_we = acc && in_mode == tcc_pkg::ModeLoad && in_tile < 4'(TILE_COUNT);
        rule_waddr = RAW'({in_tile, s_axis_tdata[7:6]});
        rule_raddr = RAW'({r_tile, r_side[1:0]});
        unique case (r_st)
            ST_CLR: begin
                we = 1'b1;
                waddr = AW'(r_cnt);
                if (r_cnt == (AW + 1)'(Cells - 1)) n_st = ST_IDLE;
            end
            ST_IDLE: begin
                if (acc && in_mode == tcc_pkg::ModeClear) n_st = ST_CLR;
                if (acc && in_mode == tcc_pkg::ModeStep) begin
                    if (w_rows == '0 || w_cols == '0) n_st = ST_OUT;
                    else n_st = ST_SCAN;
                end
            end
            ST_SCAN: if (scan_last) n_st = ST_SDRN;
            ST_SDRN: n_st = ST_SEL;
            ST_SEL: begin
                raddr = addr_of(r_br, r_bc);
                n_st = ST_DIV;  // wait for read data
            end
            ST_DIV: if (r_dbit == 4'd9) n_st = ST_PICK;
            ST_PICK: begin
                we = 1'b1;
                waddr = addr_of(r_br, r_bc);
                wdata = {1'b1, pick_tile, TILE_COUNT'(1) << pick_tile};
                n_st = ST_NRD;
            end
            ST_NRD: begin
                raddr = addr_of(nb_r, nb_c);
                if (r_side[2]) n_st = ST_OUT;
                else n_st = ST_NWR;
            end
            ST_NWR: begin
                waddr = addr_of(nb_r, nb_c);
                wdata = {rdata[EW-1:TILE_COUNT], rdata[TILE_COUNT-1:0] & rule_rdata};
                we = nb_ok && !rdata[EW-1] && r_rem == 8'd1;
                if (r_rem == 8'd1) n_st = ST_NRD;
            end
            ST_OUT: n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_CLR;
            r_cnt <= '0;
            r_rows <= 6'd32;
            r_cols <= 6'd32;
            r_ov <= 1'b0;
            r_pv <= 1'b0;
        end else begin
            r_st <= n_st;
            if (i_cfg_valid) begin
                if (i_cfg_index == tcc_pkg::CfgRows) r_rows <= i_cfg_data;
                else r_rows <= r_rows;
                if (i_cfg_index == tcc_pkg::CfgCols) r_cols <= i_cfg_data;
            end
            if (m_axis_tvalid && m_axis_tready) r_ov <= 1'b0;
            unique case (r_st)
                ST_CLR: r_cnt <= r_cnt + 1'b1;
                ST_IDLE: begin
                    r_cnt <= '0;
                    r_sr <= '0;
                    r_sc <= '0;
                    r_pv <= 1'b0;
                    r_bn <= NW'(TILE_COUNT);
                    r_found <= 1'b0;
                    r_br <= '0;
                    r_bc <= '0;
                    r_pick <= s_axis_tdata[26:19];
                    r_side <= 3'd0;
                    // a waiting result stays put until taken
                    if (acc) begin
                        r_out <= '0;
                        if (in_mode == tcc_pkg::ModeStep) r_out[1:0] <= tcc_pkg::StatComplete;
                    end
                end
                ST_SCAN, ST_SDRN: begin
                    r_pv <= (r_st == ST_SCAN);
                    r_pr <= r_sr;
                    r_pc <= r_sc;
                    if (RMaxW'(r_sc) + 1'b1 >= w_cols) begin
                        r_sc <= '0;
                        r_sr <= r_sr + 1'b1;
                    end else r_sc <= r_sc + 1'b1;
                    if (r_pv && !rdata[EW-1] && rd_n <= r_bn) begin
                        r_bn <= rd_n;
                        r_br <= r_pr;
                        r_bc <= r_pc;
                        r_found <= 1'b1;
                    end
                end
                ST_SEL: begin
                    r_rem <= '0;
                    r_dbit <= '0;
                end
                ST_DIV: begin
                    if (r_dbit == 4'd0) begin
                        r_bmask <= rdata[TILE_COUNT-1:0];
                        r_bn <= pop(rdata[TILE_COUNT-1:0]);
                    end else if (r_dbit < 4'd9) begin
                        if (!trial[8]) r_rem <= trial[7:0];
                        else r_rem <= {r_rem[6:0], r_pick[7]};
                        r_pick <= {r_pick[6:0], 1'b0};
                    end
                    r_dbit <= r_dbit + 1'b1;
                    if (r_dbit == 4'd9) begin
                        r_out[6:2] <= 5'(r_br);
                        r_out[11:7] <= 5'(r_bc);
                        if (!r_found) begin
                            r_out <= '0;
                            r_out[1:0] <= tcc_pkg::StatComplete;
                        end else if (r_bn == '0) begin
                            r_out[1:0] <= tcc_pkg::StatContra;
                        end else begin
                            r_out[1:0] <= tcc_pkg::StatCollapsed;
                        end
                    end
                end
                ST_PICK: begin
                    r_tile <= pick_tile;
                    r_out[15:12] <= 4'(pick_tile);
                    r_out[22:16] <= tcc_pkg::tile_code_of(5'(pick_tile));
                    r_rem <= 8'd0;
                end
                ST_NRD: r_rem <= 8'd1;
                ST_NWR: if (r_rem == 8'd1) r_side <= r_side + 1'b1;
                ST_OUT: r_ov <= 1'b1;
                default: ;
            endcase
            // complete or contradiction: skip collapse
            if (r_st == ST_DIV && r_dbit == 4'd9 && (!r_found || r_bn == '0)) r_st <= ST_OUT;
        end
    end

    `TCC_ASSERT_IMP(a_no_take_busy, i_clk, i_rst_n, r_st != ST_IDLE, !s_axis_tready)
    `TCC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata))
    `TCC_ASSERT_IMP(a_wr_done, i_clk, i_rst_n, r_st == ST_PICK, we && wdata[EW-1])
endmodule
`default_nettype wire

// File: tb/tcc_checker.sv
// Checker for the tile collapse core: watches all channels, predicts step results, compares
`default_nettype none
module tcc_checker
    import tcc_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    input  wire         s_axis_tready,
    input  wire  [31:0] s_axis_tdata,
    input  wire         m_axis_tvalid,
    input  wire         m_axis_tready,
    input  wire  [23:0] m_axis_tdata,
    input  wire         i_cfg_valid,
    input  wire         i_cfg_ready,
    input  wire         i_cfg_index,
    input  wire  [5:0]  i_cfg_data,
    output int          o_fail_cnt,
    output int          o_pending,
    output int          o_result_cnt,
    output int          o_contra_cnt,
    output int          o_complete_cnt
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [6:0] code;
        logic [3:0] tile;
        logic [4:0] col;
        logic [4:0] row;
        logic [1:0] stat;
    } t_step_result;

    localparam logic [6:0] TileIds [TileCount] =
        '{7'd1, 7'd38, 7'd39, 7'd40, 7'd47, 7'd48, 7'd49, 7'd56, 7'd57, 7'd58, 7'd65};

    logic [TileCount-1:0] cand_mask [MaxRows*MaxCols];
    bit                   cell_fixed [MaxRows*MaxCols];
    logic [TileCount-1:0] adj_rule [TileCount*4];
    logic [5:0]           rows_reg;
    logic [5:0]           cols_reg;
    t_step_result         expected_results [$];

    task automatic clear_cells();
        for (int i = 0; i < MaxRows*MaxCols; i++) begin
            cand_mask[i]  = '1;
            cell_fixed[i] = 1'b0;
        end
    endtask

    initial begin
        o_fail_cnt     = 0;
        o_result_cnt   = 0;
        o_contra_cnt   = 0;
        o_complete_cnt = 0;
        rows_reg       = 6'd32;
        cols_reg       = 6'd32;
        clear_cells();
        foreach (adj_rule[i]) adj_rule[i] = '0;
    end

    assign o_pending = expected_results.size();

    // one neighbor, narrowed only while still open
    task automatic narrow_cell(input int r, input int c, input int tile, input int side);
        int idx;
        idx = r * MaxCols + c;
        if (!cell_fixed[idx]) cand_mask[idx] &= adj_rule[tile*4 + side];
    endtask

    task automatic run_item(input logic [31:0] d);
        logic [1:0]   mode;
        int           nr, nc, best_r, best_c, best_n, cnt, sel, seen, tile, idx;
        bit           found;
        t_step_result res;
        mode = d[1:0];
        if (mode == ModeLoad) begin
            if (d[5:2] < TileCount) adj_rule[d[5:2]*4 + d[7:6]] = d[18:8];
        end else if (mode == ModeClear) begin
            clear_cells();
        end else if (mode == ModeStep) begin
            nr = (rows_reg > MaxRows) ? MaxRows : rows_reg;
            nc = (cols_reg > MaxCols) ? MaxCols : cols_reg;
            best_r = 0; best_c = 0; best_n = TileCount; found = 0; tile = 0;
            for (int r = 0; r < nr; r++)
                for (int c = 0; c < nc; c++) begin
                    idx = r * MaxCols + c;
                    if (!cell_fixed[idx]) begin
                        cnt = $countones(cand_mask[idx]);
                        if (cnt <= best_n) begin  // ties go to the later cell
                            best_n = cnt; best_r = r; best_c = c; found = 1;
                        end
                    end
                end
            res = '0;
            if (!found) begin
                res.stat = StatComplete;
            end else begin
                res.row = best_r[4:0];
                res.col = best_c[4:0];
                idx = best_r * MaxCols + best_c;
                cnt = $countones(cand_mask[idx]);
                if (cnt == 0) begin
                    res.stat = StatContra;
                end else begin
                    sel  = int'(d[26:19]) % cnt;
                    seen = 0;
                    // candidates counted from the highest tile down
                    for (int k = TileCount - 1; k >= 0; k--)
                        if (cand_mask[idx][k]) begin
                            if (seen == sel) begin
                                tile = k;
                                break;
                            end
                            seen++;
                        end
                    cell_fixed[idx] = 1'b1;
                    cand_mask[idx]  = '0;
                    cand_mask[idx][tile] = 1'b1;
                    if (best_r > 0) narrow_cell(best_r - 1, best_c, tile, 0);
                    if (best_c > 0) narrow_cell(best_r, best_c - 1, tile, 1);
                    if (best_r + 1 < nr) narrow_cell(best_r + 1, best_c, tile, 2);
                    if (best_c + 1 < nc) narrow_cell(best_r, best_c + 1, tile, 3);
                    res.stat = StatCollapsed;
                    res.tile = tile[3:0];
                    res.code = TileIds[tile];
                end
            end
            expected_results.push_back(res);
        end
    endtask

    always @(posedge i_clk) begin
        t_step_result got, want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[22:0];
                o_result_cnt++;
                if (got.stat == StatContra) o_contra_cnt++;
                if (got.stat == StatComplete) o_complete_cnt++;
                if (expected_results.size() == 0) begin
                    o_fail_cnt++;
                    if (o_fail_cnt <= 10) $display("unexpected result item %h", m_axis_tdata);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want || m_axis_tdata[23] !== 1'b0) begin
                        o_fail_cnt++;
                        if (o_fail_cnt <= 10)
                            $display({"mismatch: exp stat %0d r %0d c %0d t %0d id %0d,",
                                      " got stat %0d r %0d c %0d t %0d id %0d"},
                                     want.stat, want.row, want.col, want.tile, want.code,
                                     got.stat, got.row, got.col, got.tile, got.code);
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CfgRows) rows_reg = i_cfg_data;
                else cols_reg = i_cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready) run_item(s_axis_tdata);
        end
    end

    final begin
        if (expected_results.size() != 0)
            $display("%0d expected result items never arrived", expected_results.size());
    end
endmodule
`default_nettype wire

// File: tb/tb_tile_constraint_collapse_step_core.sv
// Testbench top for the tile collapse core: stimulus, handshake pacing, watchdog and verdict
`default_nettype none
module tb_tile_constraint_collapse_step_core;
    import tcc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IdleLimit  = 20000;
    localparam int DrainWait  = 1100;  // one full-grid step or clear
    localparam int ItemTarget = 540;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = CfgRows;
    logic [5:0]  i_cfg_data = '0;

    int  fail_cnt, pending, result_cnt, contra_cnt, complete_cnt;
    int  items_sent = 0;
    int  idle_cycles = 0;
    bit  no_gaps = 1'b0;
    bit  stop_rx = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    tile_constraint_collapse_step_core u_top (
        .i_clk, .i_rst_n,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data
    );

    tcc_checker u_checker (
        .i_clk, .i_rst_n,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_fail_cnt(fail_cnt), .o_pending(pending), .o_result_cnt(result_cnt),
        .o_contra_cnt(contra_cnt), .o_complete_cnt(complete_cnt)
    );

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
            $display("timeout: no handshake for %0d cycles", IdleLimit);
            $display("Verification failed");
            $finish;
        end
    end

    // receiver: random stall before each result item
    initial begin
        int stall;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 17);
            if (stall > 0) begin
                m_axis_tready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    task automatic send_item(input logic [1:0] mode, input logic [3:0] tile,
                             input logic [1:0] side, input logic [10:0] mask,
                             input logic [7:0] pick);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  = {5'd0, pick, mask, side, tile, mode};
        s_axis_tvalid = 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic end_burst();
        s_axis_tvalid = 1'b0;
    endtask

    // idle window: all results in, plus time for a trailing clear to finish
    task automatic write_reg(input logic idx, input logic [5:0] val);
        end_burst();
        while (pending != 0) @(negedge i_clk);
        repeat (DrainWait) @(negedge i_clk);
        i_cfg_index = idx;
        i_cfg_data  = val;
        i_cfg_valid = 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // dense masks keep most sequences alive past the first few collapses
    task automatic load_rule(input int t, input int s);
        logic [10:0] m;
        m = 11'($urandom) | 11'($urandom) | 11'($urandom);
        if ($urandom_range(0, 9) == 0) m = 11'($urandom);
        send_item(ModeLoad, 4'(t), 2'(s), m, 8'($urandom));
    endtask

    function automatic logic [5:0] draw_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return 6'($urandom_range(1, 6));
        if (r < 86) return 6'($urandom_range(7, 12));
        if (r < 90) return 6'd0;
        if (r < 95) return 6'd32;
        return 6'($urandom_range(33, 63));
    endfunction

    initial begin
        logic [5:0] nr, nc;
        int cells, steps;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: every rule written, edge fields, bad loads, unknown mode
        for (int t = 0; t < TileCount; t++)
            for (int s = 0; s < 4; s++)
                send_item(ModeLoad, 4'(t), 2'(s), 11'h7ff, 8'($urandom));
        send_item(ModeLoad, 4'd11, 2'd0, 11'h000, 8'h00);
        send_item(ModeLoad, 4'd15, 2'd3, 11'h7ff, 8'hff);
        send_item(2'd3, 4'd15, 2'd3, 11'h7ff, 8'hff);
        send_item(ModeStep, 4'd0, 2'd0, 11'h0, 8'hff);
        send_item(ModeStep, 4'd0, 2'd0, 11'h0, 8'h00);
        write_reg(CfgRows, 6'd0);
        send_item(ModeStep, 4'd0, 2'd0, 11'h0, 8'h5a);
        write_reg(CfgRows, 6'd1);
        write_reg(CfgCols, 6'd2);
        send_item(ModeClear, 4'd0, 2'd0, 11'h0, 8'h00);
        // empty left-hand rules force a contradiction on the first cell once the second is collapsed
        for (int t = 0; t < TileCount; t++)
            send_item(ModeLoad, 4'(t), 2'd1, 11'h000, 8'($urandom));
        send_item(ModeStep, 4'd0, 2'd0, 11'h0, 8'd7);
        send_item(ModeStep, 4'd0, 2'd0, 11'h0, 8'd200);
        send_item(ModeStep, 4'd0, 2'd0, 11'h0, 8'd1);
        for (int t = 0; t < TileCount; t++) load_rule(t, 1);
        write_reg(CfgCols, 6'd1);
        send_item(ModeClear, 4'd0, 2'd0, 11'h0, 8'h00);
        send_item(ModeStep, 4'd0, 2'd0, 11'h0, 8'd255);
        send_item(ModeStep, 4'd0, 2'd0, 11'h0, 8'd3);

        // random phases: size change, clear, then steps (enough to run a small grid out)
        while (items_sent < ItemTarget) begin
            nr = draw_size();
            nc = draw_size();
            write_reg(CfgRows, nr);
            write_reg(CfgCols, nc);
            no_gaps = ($urandom_range(0, 3) == 0);
            for (int i = $urandom_range(0, 6); i > 0; i--)
                load_rule($urandom_range(0, TileCount - 1), $urandom_range(0, 3));
            send_item(ModeClear, 4'($urandom), 2'($urandom), 11'($urandom), 8'($urandom));
            cells = (nr > 32 ? 32 : nr) * (nc > 32 ? 32 : nc);
            steps = (cells > 40) ? $urandom_range(3, 8) : cells + $urandom_range(1, 2);
            for (int i = 0; i < steps; i++) begin
                case ($urandom_range(0, 19))
                    0: send_item(2'd3, 4'($urandom), 2'($urandom), 11'($urandom),
                                 8'($urandom));
                    1: send_item(ModeLoad, 4'($urandom_range(11, 15)), 2'($urandom),
                                 11'($urandom), 8'($urandom));
                    2: load_rule($urandom_range(0, TileCount - 1), $urandom_range(0, 3));
                    default: ;
                endcase
                send_item(ModeStep, 4'($urandom), 2'($urandom), 11'($urandom),
                          8'($urandom));
                // hold off once until the block has answered everything
                if (i == 2 && $urandom_range(0, 5) == 0) begin
                    end_burst();
                    while (pending != 0) @(negedge i_clk);
                end
            end
            if ($urandom_range(0, 4) == 0)
                send_item(ModeClear, 4'd0, 2'd0, 11'h0, 8'h00);
            no_gaps = 1'b0;
        end
        end_burst();
        while (pending != 0) @(negedge i_clk);
        repeat (DrainWait) @(negedge i_clk);

        $display("Sent %0d input items; checked %0d step results", items_sent, result_cnt);
        $display("(%0d contradictions, %0d grid-complete reports)", contra_cnt, complete_cnt);
        if (fail_cnt == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches", fail_cnt);
            $display("Verification failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
